/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the refraction core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define SNRD_ASSERT_AFTER(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/snrd_pkg.sv */
// ----------------------------------------------------------------------------
// snrd_pkg
// Widths, constants and types shared by the refraction core modules.
// ----------------------------------------------------------------------------
package snrd_pkg;

  localparam int FRAC    = 14;
  localparam int FIELD_W = 16;
  localparam int ONE     = 1 << FRAC;

  localparam int COS_W  = FRAC + 1;
  localparam int EC_W   = 17;
  localparam int A_W    = 18;
  localparam int S2_W   = 21;
  localparam int RAD_W  = 2 * FRAC + 1;
  localparam int C_W    = EC_W + 1;
  localparam int R_W    = 36;
  localparam int MAG_W  = R_W - 1;
  localparam int POS_W  = 6;
  localparam int NORM_W = 30;
  localparam int SQ_W   = 2 * NORM_W + 2;
  localparam int LEN_W  = 31;
  localparam int NUM_W  = NORM_W + FRAC + 1;
  localparam int Q_W    = FRAC + 1;

  localparam int FRONT_LAT = 6 + COS_W;
  localparam int NORM_LAT  = 7 + LEN_W;
  localparam int DIV_LAT   = 1 + Q_W;
  localparam int LATENCY   = FRONT_LAT + NORM_LAT + DIV_LAT + 1;

  typedef logic [2:0][FIELD_W-1:0] vec_t;
  typedef logic [2:0][NORM_W-1:0]  norm_vec_t;
  typedef logic [2:0][Q_W-1:0]     q_vec_t;

  typedef struct packed {
    logic tir;
    logic zero;
  } ctl_t;

  typedef struct packed {
    logic [2:0] neg;
    ctl_t       ctl;
  } tag_t;

endpackage

/* rtl/core/snrd_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// snrd_sqrt_pipe
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module snrd_sqrt_pipe #(
  parameter int RAD_W  = 29,
  parameter int ROOT_W = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int W = ((RAD_W > 2 * ROOT_W) ? RAD_W : 2 * ROOT_W) + 1;

  logic              vld  [ROOT_W];
  logic [W-1:0]      rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [SIDE_W-1:0] side [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic              vld_in;
    logic [W-1:0]      rem_in;
    logic [W-1:0]      trial;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic              take;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = W'(in_rad);
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[s-1];
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
      assign side_in = side[s-1];
    end

    assign trial = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
      rem[s]  <= take ? rem_in - trial : rem_in;
      root[s] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
      side[s] <= side_in;
    end
  end

  assign out_vld  = vld[ROOT_W-1];
  assign out_root = root[ROOT_W-1];
  assign out_side = side[ROOT_W-1];

endmodule

/* rtl/core/snrd_div_pipe.sv */
// ----------------------------------------------------------------------------
// snrd_div_pipe
// Three-lane pipelined restoring divider that divides each component by the
// vector length, one quotient bit per register stage after a rounding pre-stage.
// ----------------------------------------------------------------------------
module snrd_div_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  snrd_pkg::norm_vec_t          in_mag,
  input  logic [snrd_pkg::LEN_W-1:0]   in_den,
  input  snrd_pkg::tag_t               in_tag,
  output logic                         out_vld,
  output snrd_pkg::q_vec_t             out_q,
  output snrd_pkg::tag_t               out_tag
);

  localparam int NW = snrd_pkg::NUM_W;
  localparam int QW = snrd_pkg::Q_W;

  logic                       pre_vld;
  logic [2:0][NW-1:0]         pre_rem;
  logic [snrd_pkg::LEN_W-1:0] pre_den;
  snrd_pkg::tag_t             pre_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else begin
      pre_vld <= in_vld;
    end
    for (int i = 0; i < 3; i++) begin
      pre_rem[i] <= (NW'(in_mag[i]) << snrd_pkg::FRAC) + NW'(in_den >> 1);
    end
    pre_den <= in_den;
    pre_tag <= in_tag;
  end

  logic                       vld [QW];
  logic [2:0][NW-1:0]         rem [QW];
  snrd_pkg::q_vec_t           q   [QW];
  logic [snrd_pkg::LEN_W-1:0] den [QW];
  snrd_pkg::tag_t             tag [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic                       vld_in;
    logic [2:0][NW-1:0]         rem_in;
    snrd_pkg::q_vec_t           q_in;
    logic [snrd_pkg::LEN_W-1:0] den_in;
    snrd_pkg::tag_t             tag_in;
    logic [NW-1:0]              dsh;

    if (s == 0) begin : g_first
      assign vld_in = pre_vld;
      assign rem_in = pre_rem;
      assign q_in   = '0;
      assign den_in = pre_den;
      assign tag_in = pre_tag;
    end else begin : g_next
      assign vld_in = vld[s-1];
      assign rem_in = rem[s-1];
      assign q_in   = q[s-1];
      assign den_in = den[s-1];
      assign tag_in = tag[s-1];
    end

    assign dsh = NW'(den_in) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dsh) begin
          rem[s][i] <= rem_in[i] - dsh;
          q[s][i]   <= q_in[i] | (QW'(1) << B);
        end else begin
          rem[s][i] <= rem_in[i];
          q[s][i]   <= q_in[i];
        end
      end
      den[s] <= den_in;
      tag[s] <= tag_in;
    end
  end

  assign out_vld = vld[QW-1];
  assign out_q   = q[QW-1];
  assign out_tag = tag[QW-1];

endmodule

/* rtl/core/snrd_front.sv */
// ----------------------------------------------------------------------------
// snrd_front
// Cosine of incidence, transmitted sine squared, total internal reflection
// test, transmitted cosine and the normal coefficient.
// ----------------------------------------------------------------------------
module snrd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [15:0]                 incident_x,
  input  logic signed [15:0]                 incident_y,
  input  logic signed [15:0]                 incident_z,
  input  logic signed [15:0]                 normal_x,
  input  logic signed [15:0]                 normal_y,
  input  logic signed [15:0]                 normal_z,
  input  logic [15:0]                        eta_ratio,
  output logic                               out_vld,
  output logic signed [snrd_pkg::C_W-1:0]    out_c,
  output snrd_pkg::vec_t                     out_v,
  output snrd_pkg::vec_t                     out_n,
  output logic [15:0]                        out_eta,
  output logic                               out_tir
);

  localparam int F   = snrd_pkg::FRAC;
  localparam int CW  = snrd_pkg::COS_W;
  localparam int MW  = 35;

  typedef struct packed {
    snrd_pkg::vec_t             v;
    snrd_pkg::vec_t             n;
    logic [15:0]                eta;
    logic [snrd_pkg::EC_W-1:0]  ec;
    logic                       tir;
  } side_t;

  logic               vld1;
  snrd_pkg::vec_t     v1, n1;
  logic [15:0]        eta1;
  logic signed [31:0] p1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start;
    end
    v1    <= {incident_z, incident_y, incident_x};
    n1    <= {normal_z, normal_y, normal_x};
    eta1  <= eta_ratio;
    p1[0] <= incident_x * normal_x;
    p1[1] <= incident_y * normal_y;
    p1[2] <= incident_z * normal_z;
  end

  logic signed [33:0] dot2, neg_dot2;
  logic [33:0]        rnd2;
  logic [CW-1:0]      cos_next;

  always_comb begin
    dot2     = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]);
    neg_dot2 = -dot2;
    rnd2     = (34'(neg_dot2) + 34'(1 << (F - 1))) >> F;
    if (neg_dot2 > 0) begin
      cos_next = (rnd2 > 34'(snrd_pkg::ONE)) ? CW'(snrd_pkg::ONE) : CW'(rnd2);
    end else begin
      cos_next = '0;
    end
  end

  logic           vld2;
  snrd_pkg::vec_t v2, n2;
  logic [15:0]    eta2;
  logic [CW-1:0]  cos2_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    v2     <= v1;
    n2     <= n1;
    eta2   <= eta1;
    cos2_i <= cos_next;
  end

  logic [2*CW-1:0]           sq3;
  logic [2*CW-1:0]           csq3;
  logic [MW-1:0]             ecp3;
  logic                      vld3;
  snrd_pkg::vec_t            v3, n3;
  logic [15:0]               eta3;
  logic [CW-1:0]             om3;
  logic [snrd_pkg::EC_W-1:0] ec3;

  always_comb begin
    sq3  = cos2_i * cos2_i;
    csq3 = (sq3 + (2*CW)'(1 << (F - 1))) >> F;
    ecp3 = (MW'(eta2) * MW'(cos2_i) + MW'(1 << (F - 2))) >> (F - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    v3   <= v2;
    n3   <= n2;
    eta3 <= eta2;
    om3  <= CW'((2*CW)'(snrd_pkg::ONE) - csq3);
    ec3  <= snrd_pkg::EC_W'(ecp3);
  end

  logic [MW-1:0]             ap4;
  logic                      vld4;
  snrd_pkg::vec_t            v4, n4;
  logic [15:0]               eta4;
  logic [snrd_pkg::A_W-1:0]  a4;
  logic [snrd_pkg::EC_W-1:0] ec4;

  assign ap4 = (MW'(eta3) * MW'(om3) + MW'(1 << (F - 2))) >> (F - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
    v4   <= v3;
    n4   <= n3;
    eta4 <= eta3;
    ec4  <= ec3;
    a4   <= snrd_pkg::A_W'(ap4);
  end

  logic [MW-1:0]             sp5;
  logic [snrd_pkg::S2_W-1:0] s2_5;
  logic                      tir_next;
  logic                      vld5;
  logic [snrd_pkg::RAD_W-1:0] rad5;
  side_t                     side5;

  always_comb begin
    sp5      = (MW'(eta4) * MW'(a4) + MW'(1 << (F - 2))) >> (F - 1);
    s2_5     = snrd_pkg::S2_W'(sp5);
    tir_next = s2_5 > snrd_pkg::S2_W'(snrd_pkg::ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
    if (tir_next) begin
      rad5 <= '0;
    end else begin
      rad5 <= snrd_pkg::RAD_W'(snrd_pkg::S2_W'(snrd_pkg::ONE) - s2_5) << F;
    end
    side5.v   <= v4;
    side5.n   <= n4;
    side5.eta <= eta4;
    side5.ec  <= ec4;
    side5.tir <= tir_next;
  end

  logic          sq_vld;
  logic [CW-1:0] cos_t;
  side_t         sq_side;

  snrd_sqrt_pipe #(
    .RAD_W (snrd_pkg::RAD_W),
    .ROOT_W(CW),
    .SIDE_W($bits(side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld5),
    .in_rad  (rad5),
    .in_side (side5),
    .out_vld (sq_vld),
    .out_root(cos_t),
    .out_side(sq_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= sq_vld;
    end
    out_c   <= $signed({1'b0, sq_side.ec}) - $signed({3'b000, cos_t});
    out_v   <= sq_side.v;
    out_n   <= sq_side.n;
    out_eta <= sq_side.eta;
    out_tir <= sq_side.tir;
  end

endmodule

/* rtl/core/snrd_norm.sv */
// ----------------------------------------------------------------------------
// snrd_norm
// Unnormalized refracted vector, magnitude scaling by powers of two and the
// vector length.
// ----------------------------------------------------------------------------
module snrd_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [snrd_pkg::C_W-1:0]  in_c,
  input  snrd_pkg::vec_t                   in_v,
  input  snrd_pkg::vec_t                   in_n,
  input  logic [15:0]                      in_eta,
  input  logic                             in_tir,
  output logic                             out_vld,
  output logic [snrd_pkg::LEN_W-1:0]       out_len,
  output snrd_pkg::norm_vec_t              out_mag,
  output snrd_pkg::tag_t                   out_tag
);

  localparam int RW = snrd_pkg::R_W;
  localparam int MW = snrd_pkg::MAG_W;
  localparam int NW = snrd_pkg::NORM_W;
  localparam int PW = snrd_pkg::POS_W;

  typedef struct packed {
    snrd_pkg::norm_vec_t mag;
    snrd_pkg::tag_t      tag;
  } side_t;

  function automatic logic [PW-1:0] lead_pos(input logic [MW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int k = 0; k < MW; k++) begin
      if (x[k]) begin
        p = PW'(k);
      end
    end
    return p;
  endfunction

  logic               vld1;
  logic signed [32:0] pe1 [3];
  logic signed [33:0] pc1 [3];
  logic               tir1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    for (int i = 0; i < 3; i++) begin
      pe1[i] <= $signed({1'b0, in_eta}) * $signed(in_v[i]);
      pc1[i] <= in_c * $signed(in_n[i]);
    end
    tir1 <= in_tir;
  end

  logic signed [RW-1:0] r2 [3];
  logic                 vld2;
  logic [MW-1:0]        mag2 [3];
  logic [2:0]           neg2;
  logic                 tir2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i] = (RW'(pe1[i]) <<< 1) + RW'(pc1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    for (int i = 0; i < 3; i++) begin
      mag2[i] <= r2[i][RW-1] ? MW'(-r2[i]) : MW'(r2[i]);
      neg2[i] <= r2[i][RW-1];
    end
    tir2 <= tir1;
  end

  logic [MW-1:0] m01;
  logic          vld3;
  logic [MW-1:0] mag3 [3];
  logic [MW-1:0] max3;
  logic [2:0]    neg3;
  logic          tir3;

  assign m01 = (mag2[0] > mag2[1]) ? mag2[0] : mag2[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    mag3 <= mag2;
    max3 <= (m01 > mag2[2]) ? m01 : mag2[2];
    neg3 <= neg2;
    tir3 <= tir2;
  end

  logic          vld4;
  logic [MW-1:0] mag4 [3];
  logic [PW-1:0] pos4;
  logic [2:0]    neg4;
  snrd_pkg::ctl_t ctl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
    mag4      <= mag3;
    pos4      <= lead_pos(max3);
    neg4      <= neg3;
    ctl4.tir  <= tir3;
    ctl4.zero <= (max3 == '0);
  end

  logic           vld5;
  snrd_pkg::norm_vec_t nm5;
  snrd_pkg::tag_t tag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
    for (int i = 0; i < 3; i++) begin
      if (pos4 >= PW'(NW - 1)) begin
        nm5[i] <= NW'(mag4[i] >> (pos4 - PW'(NW - 1)));
      end else begin
        nm5[i] <= NW'(mag4[i] << (PW'(NW - 1) - pos4));
      end
    end
    tag5.neg <= neg4;
    tag5.ctl <= ctl4;
  end

  logic              vld6;
  logic [2*NW-1:0]   sq6 [3];
  snrd_pkg::norm_vec_t nm6;
  snrd_pkg::tag_t    tag6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else begin
      vld6 <= vld5;
    end
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= nm5[i] * nm5[i];
    end
    nm6  <= nm5;
    tag6 <= tag5;
  end

  logic                     vld7;
  logic [snrd_pkg::SQ_W-1:0] sum7;
  side_t                    side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld7 <= 1'b0;
    end else begin
      vld7 <= vld6;
    end
    sum7 <= snrd_pkg::SQ_W'(sq6[0]) + snrd_pkg::SQ_W'(sq6[1]) + snrd_pkg::SQ_W'(sq6[2]);
    side7.mag <= nm6;
    side7.tag <= tag6;
  end

  side_t sq_side;

  snrd_sqrt_pipe #(
    .RAD_W (snrd_pkg::SQ_W),
    .ROOT_W(snrd_pkg::LEN_W),
    .SIDE_W($bits(side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld7),
    .in_rad  (sum7),
    .in_side (side7),
    .out_vld (out_vld),
    .out_root(out_len),
    .out_side(sq_side)
  );

  assign out_mag = sq_side.mag;
  assign out_tag = sq_side.tag;

endmodule

/* rtl/core/snell_refraction_direction_core.sv */
// ----------------------------------------------------------------------------
// snell_refraction_direction_core
// Refracted ray direction by Snell's law in fixed point, fully pipelined.
//
//   Channel   Handshake            Payload
//   input     start, busy          incident_x/y/z, normal_x/y/z, eta_ratio
//   result    done (strobe)        refracted_x/y/z, internal_reflection
//
// One item enters per cycle; busy is always low.
// The pipeline depth is set mostly by the two bit-serial square root pipelines
// (15 and 31 stages) and the divider (a rounding stage, 15 quotient stages).
// Synchronous reset clears all valid bits; items in flight are dropped.
// The result strobe cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module snell_refraction_direction_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] incident_x,
  input  logic signed [15:0] incident_y,
  input  logic signed [15:0] incident_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0]        eta_ratio,
  output logic               done,
  output logic signed [15:0] refracted_x,
  output logic signed [15:0] refracted_y,
  output logic signed [15:0] refracted_z,
  output logic               internal_reflection
);

  `include "assert_macros.svh"

  logic                            f_vld;
  logic signed [snrd_pkg::C_W-1:0] f_c;
  snrd_pkg::vec_t                  f_v, f_n;
  logic [15:0]                     f_eta;
  logic                            f_tir;

  assign busy = 1'b0;

  snrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .incident_x(incident_x),
    .incident_y(incident_y),
    .incident_z(incident_z),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .eta_ratio (eta_ratio),
    .out_vld   (f_vld),
    .out_c     (f_c),
    .out_v     (f_v),
    .out_n     (f_n),
    .out_eta   (f_eta),
    .out_tir   (f_tir)
  );

  logic                         n_vld;
  logic [snrd_pkg::LEN_W-1:0]   n_len;
  snrd_pkg::norm_vec_t          n_mag;
  snrd_pkg::tag_t               n_tag;

  snrd_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .in_vld (f_vld),
    .in_c   (f_c),
    .in_v   (f_v),
    .in_n   (f_n),
    .in_eta (f_eta),
    .in_tir (f_tir),
    .out_vld(n_vld),
    .out_len(n_len),
    .out_mag(n_mag),
    .out_tag(n_tag)
  );

  logic             d_vld;
  snrd_pkg::q_vec_t d_q;
  snrd_pkg::tag_t   d_tag;

  snrd_div_pipe u_div (
    .clk    (clk),
    .rst    (rst),
    .in_vld (n_vld),
    .in_mag (n_mag),
    .in_den (n_len),
    .in_tag (n_tag),
    .out_vld(d_vld),
    .out_q  (d_q),
    .out_tag(d_tag)
  );

  logic signed [15:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_tag.ctl.tir || d_tag.ctl.zero) begin
        comp[i] = '0;
      end else if (d_tag.neg[i]) begin
        comp[i] = -$signed({1'b0, d_q[i]});
      end else begin
        comp[i] = $signed({1'b0, d_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
    refracted_x         <= comp[0];
    refracted_y         <= comp[1];
    refracted_z         <= comp[2];
    internal_reflection <= d_tag.ctl.tir;
  end

  `SNRD_ASSERT_AFTER(a_fixed_latency, clk, rst, start && !busy, snrd_pkg::LATENCY, done)
  `SNRD_ASSERT_NOW(a_tir_zero, clk, rst, done && internal_reflection, refracted_x == 16'sd0 && refracted_y == 16'sd0 && refracted_z == 16'sd0)
  `SNRD_ASSERT_NOW(a_unit_bound, clk, rst, done && !internal_reflection, refracted_x <= 16'sd16384 && refracted_x >= -16'sd16384 && refracted_y <= 16'sd16384 && refracted_y >= -16'sd16384 && refracted_z <= 16'sd16384 && refracted_z >= -16'sd16384)

endmodule
